FILE: sv/mmcn_pkg.sv
// Shared types and constants for the min-max column normalizer.
// Holds the request/response payload structs, controller states and
// controller/datapath command and status groups. No dependencies.
package mmcn_pkg;

   // Fixed-point format of the scaled result
   localparam int FRACTION_BITS = 16;
   localparam int SCALED_W      = FRACTION_BITS + 1;
   localparam int DIV_STEPS     = FRACTION_BITS + 1;
   localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

   // Operation codes
   localparam logic OP_LEARN     = 1'b0;
   localparam logic OP_NORMALIZE = 1'b1;

   // CSR map: register index is paddr[2]
   localparam int          CSR_ADDR_W           = 3;
   localparam logic        CSR_IDX_COLUMN_COUNT = 1'b0;
   localparam logic [6:0]  COLUMN_COUNT_RESET   = 7'd64;

   typedef struct packed {
      logic               operation;
      logic [5:0]         column;
      logic signed [31:0] sample_value;
      logic               first_row;
   } req_payload_type;

   typedef struct packed {
      logic [5:0]          result_column;
      logic [SCALED_W-1:0] scaled_value;
      logic signed [31:0]  learned_min;
      logic signed [31:0]  learned_max;
      logic                flat_column;
      logic                clamped;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_CHECK,
      ST_DIV,
      ST_OUT
   } ctrl_state_type;

   // Controller -> datapath
   typedef struct packed {
      logic capture;
      logic load;
      logic write_store;
      logic check;
      logic div_step;
   } ctrl_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic ignored;
      logic is_learn;
      logic div_needed;
      logic div_done;
   } dp_status_type;

endpackage

FILE: sv/mmcn_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Standalone; no package dependencies.
module mmcn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/mmcn_ctrl.sv
// Controller state machine for the min-max column normalizer.
// Depends on mmcn_pkg for states and command/status structs.
module mmcn_ctrl
   import mmcn_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd,
   output logic          busy,
   output logic          emit
);

   ctrl_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.ignored || status.is_learn) state_in = ST_IDLE;
            else                                   state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.div_needed) state_in = ST_DIV;
            else                   state_in = ST_OUT;
         end
         ST_DIV: begin
            if (status.div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd         = '0;
      busy        = 1'b1;
      emit        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         ST_LOAD: begin
            cmd.load        = 1'b1;
            cmd.write_store = !status.ignored && status.is_learn;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_OUT: begin
            emit = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   // An accepted item always goes to the store lookup
   a_accept_load: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_LOAD))
      else $error("accepted item did not enter lookup");

   // A result strobe lasts one cycle and frees the block
   a_out_once: assert property (@(posedge clock) disable iff (reset)
      emit |=> (!emit && !busy))
      else $error("result strobe not followed by idle");

   // A range check that needs no divide, or the last divide step, is followed by a result
   a_out_source: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && !status.div_needed) || (state_ff == ST_DIV && status.div_done)
      |=> emit)
      else $error("missing result strobe");

   // Learn and ignored items never reach the range check
   a_learn_no_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD && (status.ignored || status.is_learn)) |=> !busy)
      else $error("learn or ignored item kept block busy");
`endif

endmodule

FILE: sv/mmcn_datapath.sv
// Datapath for the min-max column normalizer: min/max stores, range and
// offset arithmetic, and a restoring divider. Depends on mmcn_pkg, mmcn_ram.
module mmcn_datapath
   import mmcn_pkg::*;
#(
   parameter int MAX_COLUMNS = 64
) (
   input  logic            clock,
   input  req_payload_type req_payload,
   input  logic [6:0]      column_count,
   input  ctrl_cmd_type    cmd,
   output dp_status_type   status,
   output rsp_payload_type rsp_payload
);

   localparam int ADDR_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

   req_payload_type     req_ff;
   logic signed [31:0]  mn_ff, mx_ff;
   logic signed [32:0]  range_ff, diff_ff;
   logic [31:0]         divisor_ff;
   logic [32:0]         rem_ff;
   logic [SCALED_W-1:0] scaled_ff;
   logic                flat_ff, clamp_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;

   logic [31:0]         rd_min, rd_max;
   logic signed [31:0]  new_min, new_max;
   logic                range_nonpos, diff_neg, diff_over;
   logic                div_ge;
   logic [32:0]         rem_sub;

   // Column stores, read at the incoming column on acceptance
   mmcn_ram #(.WIDTH(32), .DEPTH(MAX_COLUMNS)) u_min_store (
      .clock   (clock),
      .wr_en   (cmd.write_store),
      .wr_addr (ADDR_W'(req_ff.column)),
      .wr_data (new_min),
      .rd_addr (ADDR_W'(req_payload.column)),
      .rd_data (rd_min)
   );

   mmcn_ram #(.WIDTH(32), .DEPTH(MAX_COLUMNS)) u_max_store (
      .clock   (clock),
      .wr_en   (cmd.write_store),
      .wr_addr (ADDR_W'(req_ff.column)),
      .wr_data (new_max),
      .rd_addr (ADDR_W'(req_payload.column)),
      .rd_data (rd_max)
   );

   // Learn update of min and max
   always_comb begin
      if (req_ff.first_row) begin
         new_min = req_ff.sample_value;
         new_max = req_ff.sample_value;
      end else begin
         new_min = (req_ff.sample_value < $signed(rd_min)) ? req_ff.sample_value
                                                           : $signed(rd_min);
         new_max = (req_ff.sample_value > $signed(rd_max)) ? req_ff.sample_value
                                                           : $signed(rd_max);
      end
   end

   // Range classification
   assign range_nonpos = range_ff[32] || (range_ff == '0);
   assign diff_neg     = diff_ff[32];
   assign diff_over    = diff_ff > range_ff;

   // One restoring divide step
   assign div_ge  = rem_ff >= {1'b0, divisor_ff};
   assign rem_sub = div_ge ? (rem_ff - {1'b0, divisor_ff}) : rem_ff;

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
   end

   // Store lookup: keep min/max and form range and offset
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mn_ff    <= $signed(rd_min);
         mx_ff    <= $signed(rd_max);
         range_ff <= {rd_max[31], rd_max} - {rd_min[31], rd_min};
         diff_ff  <= {req_ff.sample_value[31], req_ff.sample_value} - {rd_min[31], rd_min};
      end
   end

   // Range check and divider
   always_ff @(posedge clock) begin
      if (cmd.check) begin
         flat_ff    <= range_nonpos;
         clamp_ff   <= !range_nonpos && (diff_neg || diff_over);
         scaled_ff  <= (!range_nonpos && !diff_neg && diff_over) ?
                       SCALED_W'(1) << FRACTION_BITS : '0;
         rem_ff     <= {1'b0, diff_ff[31:0]};
         divisor_ff <= range_ff[31:0];
         cnt_ff     <= '0;
      end else if (cmd.div_step) begin
         scaled_ff <= {scaled_ff[SCALED_W-2:0], div_ge};
         rem_ff    <= {rem_sub[31:0], 1'b0};
         cnt_ff    <= cnt_ff + 1'b1;
      end
   end

   // Status to controller
   assign status.ignored    = ({1'b0, req_ff.column} >= column_count) ||
                              (32'(req_ff.column) >= 32'(MAX_COLUMNS));
   assign status.is_learn   = (req_ff.operation == OP_LEARN);
   assign status.div_needed = !range_nonpos && !diff_neg && !diff_over;
   assign status.div_done   = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   // Result payload
   assign rsp_payload.result_column = req_ff.column;
   assign rsp_payload.scaled_value  = scaled_ff;
   assign rsp_payload.learned_min   = mn_ff;
   assign rsp_payload.learned_max   = mx_ff;
   assign rsp_payload.flat_column   = flat_ff;
   assign rsp_payload.clamped       = clamp_ff;

endmodule

FILE: sv/min_max_column_normalizer_unit.sv
// Min-max column normalizer. Learn and ignored items return to idle after the
// store lookup; normalize items that clamp or hit a flat column pass the lookup,
// the range check and the result strobe; divided items run the 17-step restoring
// divider (one quotient bit a cycle) between the range check and the strobe.
// Synchronous active-high reset idles the controller and sets column_count to
// 64; stores are not cleared. The result receiver cannot stall.
module min_max_column_normalizer_unit
   import mmcn_pkg::*;
#(
   parameter int MAX_COLUMNS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // command channel
   input  logic                  start,
   output logic                  busy,
   input  req_payload_type       req_payload,
   // result channel
   output logic                  rsp_valid,
   output rsp_payload_type       rsp_payload,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic [6:0]    column_count_ff;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Column count register
   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= COLUMN_COUNT_RESET;
      end else if (psel && penable && pwrite && pready &&
                   paddr[2] == CSR_IDX_COLUMN_COUNT) begin
         column_count_ff <= pwdata[6:0];
      end
   end

   // CSR read
   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_IDX_COLUMN_COUNT) ? {25'd0, column_count_ff} : 32'd0;

   mmcn_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy),
      .emit   (rsp_valid)
   );

   mmcn_datapath #(.MAX_COLUMNS(MAX_COLUMNS)) u_datapath (
      .clock        (clock),
      .req_payload  (req_payload),
      .column_count (column_count_ff),
      .cmd          (cmd),
      .status       (status),
      .rsp_payload  (rsp_payload)
   );

endmodule

FILE: verif/tb.sv
// Self-checking bench for min_max_column_normalizer_unit: directed table, then random
// learn/normalize traffic over several column_count settings, scored against a local model.
// Depends on mmcn_pkg and the normalizer RTL only.
`timescale 1ns / 1ps

module tb
   import mmcn_pkg::*;
();

   localparam int         MAX_COLS       = 64;
   localparam int         DRAIN_CYCLES   = 25;
   localparam int         END_CYCLES     = 30;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         REPORT_LIMIT   = 10;
   localparam int         RANDOM_PHASES  = 8;
   localparam int         PHASE_ITEMS    = 104;
   localparam logic [6:0] KEEP_COUNT     = 7'd0;

   typedef struct {
      logic [6:0]      set_count;
      req_payload_type req;
      bit              typed_ok;
      rsp_payload_type typed;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   rsp_payload_type       rsp_payload;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   // local copy of the learned bounds and of the register
   logic signed [31:0] col_min [MAX_COLS];
   logic signed [31:0] col_max [MAX_COLS];
   bit                 col_learned [MAX_COLS];
   logic [6:0]         active_count = COLUMN_COUNT_RESET;

   rsp_payload_type norm_expected [$];
   stim_row_type    directed_rows [$];
   rsp_payload_type oldest_result;
   int              fail_count = 0;
   int              idle_cycles = 0;
   int              burst_left = 0;

   min_max_column_normalizer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic req_payload_type mk_req(input logic op, input logic [5:0] col,
                                              input logic [31:0] val, input logic first);
      return {op, col, val, first};
   endfunction

   function automatic rsp_payload_type mk_rsp(input logic [5:0] col, input logic [16:0] scaled,
                                              input logic [31:0] mn, input logic [31:0] mx,
                                              input logic flat, input logic clamp);
      return {col, scaled, mn, mx, flat, clamp};
   endfunction

   function automatic void add_row(input logic [6:0] set_count, input req_payload_type req,
                                   input bit typed_ok, input rsp_payload_type typed);
      stim_row_type row;
      row.set_count = set_count;
      row.req       = req;
      row.typed_ok  = typed_ok;
      row.typed     = typed;
      directed_rows.push_back(row);
   endfunction

   task automatic note_failure(input string msg);
      if (fail_count < REPORT_LIMIT) $display("ERROR: %s", msg);
      fail_count++;
   endtask

   // Normalizer model: updates bounds on learn, returns 1 with the result on normalize; ignored columns change nothing
   function automatic bit predict_normalize(input req_payload_type p, output rsp_payload_type r);
      longint     mn, mx, v, span, diff;
      logic [16:0] scaled;
      logic        flat, clamp;
      r = '0;
      if (p.column >= active_count || int'(p.column) >= MAX_COLS) return 0;
      mn = col_min[p.column];
      mx = col_max[p.column];
      v  = $signed(p.sample_value);
      if (p.operation == OP_LEARN) begin
         if (p.first_row) begin
            mn = v;
            mx = v;
         end else begin
            if (v < mn) mn = v;
            if (v > mx) mx = v;
         end
         col_min[p.column]     = mn[31:0];
         col_max[p.column]     = mx[31:0];
         col_learned[p.column] = 1'b1;
         return 0;
      end
      span   = mx - mn;
      diff   = v - mn;
      scaled = '0;
      flat   = 1'b0;
      clamp  = 1'b0;
      if (span <= 0) begin
         flat = 1'b1;
      end else if (diff < 0) begin
         clamp = 1'b1;
      end else if (diff > span) begin
         scaled = 17'(1 << FRACTION_BITS);
         clamp  = 1'b1;
      end else begin
         scaled = 17'((diff << FRACTION_BITS) / span);
      end
      r = mk_rsp(p.column, scaled, mn[31:0], mx[31:0], flat, clamp);
      return 1;
   endfunction

   // Random item: mostly learned columns in use, some ignored columns as noise
   function automatic req_payload_type gen_item();
      req_payload_type  p;
      int               lim, sel, c;
      longint           mn, mx, v;
      longint unsigned  span, r64;
      lim = (int'(active_count) > MAX_COLS) ? MAX_COLS : int'(active_count);
      sel = $urandom_range(0, 99);
      if (sel < 70) c = $urandom_range(0, ((lim < 8) ? lim : 8) - 1);
      else if (sel < 85) c = $urandom_range(0, lim - 1);
      else c = $urandom_range(0, 63);
      p.column = c[5:0];
      if (c >= lim) begin
         p.operation    = logic'($urandom_range(0, 1));
         p.sample_value = $urandom;
         p.first_row    = logic'($urandom_range(0, 1));
         return p;
      end
      if (col_learned[c] && $urandom_range(0, 99) < 55) begin
         // normalize around the learned range
         p.operation = OP_NORMALIZE;
         p.first_row = logic'($urandom_range(0, 1));
         mn   = col_min[c];
         mx   = col_max[c];
         span = longint'(mx - mn);
         sel  = $urandom_range(0, 99);
         if (sel < 45) begin
            r64 = {$urandom, $urandom};
            v   = mn + longint'(r64 % (span + 1));
         end else if (sel < 55) begin
            v = mn;
         end else if (sel < 65) begin
            v = mx;
         end else if (sel < 75) begin
            v = mn - $urandom_range(1, 32'h0003_0000);
            if (v < -64'sh8000_0000) v = -64'sh8000_0000;
         end else if (sel < 85) begin
            v = mx + $urandom_range(1, 32'h0003_0000);
            if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
         end else begin
            v = $signed($urandom);
         end
         p.sample_value = v[31:0];
         return p;
      end
      // learn: unlearned columns must start with a first-row value
      p.operation = OP_LEARN;
      p.first_row = col_learned[c] ? ($urandom_range(0, 99) < 8) : 1'b1;
      sel = $urandom_range(0, 99);
      if (sel < 20) begin
         p.sample_value = $urandom;
      end else if (sel < 35) begin
         case ($urandom_range(0, 3))
            0: p.sample_value = 32'h8000_0000;
            1: p.sample_value = 32'h7FFF_FFFF;
            2: p.sample_value = 32'h0000_0000;
            default: p.sample_value = 32'hFFFF_FFFF;
         endcase
      end else begin
         p.sample_value = 32'($urandom_range(0, 32'h000A_0000)) - 32'h0005_0000;
      end
      return p;
   endfunction

   // One transfer on the command channel, then score it
   task automatic issue(input req_payload_type p, input bit typed_ok,
                        input rsp_payload_type typed);
      rsp_payload_type pred;
      bit              has_result;
      req_payload <= p;
      start       <= 1'b1;
      do @(posedge clock); while (busy);
      has_result = predict_normalize(p, pred);
      if (typed_ok) norm_expected.push_back(typed);
      else if (has_result) norm_expected.push_back(pred);
   endtask

   // Sender gap: mostly short, a few long, with back-to-back bursts
   task automatic pause_sender();
      int r, gap;
      r = $urandom_range(0, 99);
      if (r < 55) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 60);
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else if ($urandom_range(0, 49) == 0) begin
         burst_left = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Idle the block before touching the register
   task automatic drain();
      start <= 1'b0;
      while (norm_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // APB write of column_count, then read it back
   task automatic csr_write_count(input logic [6:0] value);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {CSR_IDX_COLUMN_COUNT, 2'b00};
      pwdata  <= {25'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      active_count = value;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[6:0] !== value)
         note_failure($sformatf("column_count readback %0d, wrote %0d", prdata[6:0], value));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Result checker: every strobe must match the oldest pending result
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (norm_expected.size() == 0) begin
            note_failure($sformatf("unexpected result col %0d scaled %0d",
                                   rsp_payload.result_column, rsp_payload.scaled_value));
         end else begin
            oldest_result = norm_expected.pop_front();
            if (rsp_payload !== oldest_result)
               note_failure($sformatf(
                  {"col %0d scaled %0d min %h max %h flat %b clamp %b / ",
                   "want col %0d scaled %0d min %h max %h flat %b clamp %b"},
                  rsp_payload.result_column, rsp_payload.scaled_value,
                  rsp_payload.learned_min, rsp_payload.learned_max,
                  rsp_payload.flat_column, rsp_payload.clamped,
                  oldest_result.result_column, oldest_result.scaled_value,
                  oldest_result.learned_min, oldest_result.learned_max,
                  oldest_result.flat_column, oldest_result.clamped));
         end
      end
   end

   // Watchdog on cycles with no transfer of any kind
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (psel && penable)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      // directed table: bounds, extremes, clamps, flat columns, ignored columns
      add_row(KEEP_COUNT, mk_req(OP_LEARN, 6'd0, 32'h0005_0000, 1'b1), 0, '0);
      add_row(KEEP_COUNT, mk_req(OP_NORMALIZE, 6'd0, 32'h0005_0000, 1'b0), 1,
              mk_rsp(6'd0, 17'd0, 32'h0005_0000, 32'h0005_0000, 1'b1, 1'b0));
      add_row(KEEP_COUNT, mk_req(OP_LEARN, 6'd0, 32'h8000_0000, 1'b0), 0, '0);
      add_row(KEEP_COUNT, mk_req(OP_LEARN, 6'd0, 32'h7FFF_FFFF, 1'b0), 0, '0);
      add_row(KEEP_COUNT, mk_req(OP_NORMALIZE, 6'd0, 32'h7FFF_FFFF, 1'b0), 1,
              mk_rsp(6'd0, 17'd65536, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0));
      add_row(KEEP_COUNT, mk_req(OP_NORMALIZE, 6'd0, 32'h8000_0000, 1'b1), 1,
              mk_rsp(6'd0, 17'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0));
      add_row(KEEP_COUNT, mk_req(OP_NORMALIZE, 6'd0, 32'h0000_0000, 1'b0), 0, '0);
      add_row(KEEP_COUNT, mk_req(OP_LEARN, 6'd1, 32'h0000_0000, 1'b1), 0, '0);
      add_row(KEEP_COUNT, mk_req(OP_LEARN, 6'd1, 32'h0002_0000, 1'b0), 0, '0);
      add_row(KEEP_COUNT, mk_req(OP_NORMALIZE, 6'd1, 32'h0001_0000, 1'b0), 1,
              mk_rsp(6'd1, 17'd32768, 32'h0000_0000, 32'h0002_0000, 1'b0, 1'b0));
      add_row(KEEP_COUNT, mk_req(OP_NORMALIZE, 6'd1, 32'h0003_0000, 1'b0), 1,
              mk_rsp(6'd1, 17'd65536, 32'h0000_0000, 32'h0002_0000, 1'b0, 1'b1));
      add_row(KEEP_COUNT, mk_req(OP_NORMALIZE, 6'd1, 32'hFFFF_FFFF, 1'b0), 1,
              mk_rsp(6'd1, 17'd0, 32'h0000_0000, 32'h0002_0000, 1'b0, 1'b1));
      add_row(KEEP_COUNT, mk_req(OP_NORMALIZE, 6'd1, 32'h0000_5555, 1'b0), 0, '0);
      add_row(KEEP_COUNT, mk_req(OP_LEARN, 6'd63, 32'h7FFF_FFFF, 1'b1), 0, '0);
      add_row(KEEP_COUNT, mk_req(OP_NORMALIZE, 6'd63, 32'h8000_0000, 1'b0), 1,
              mk_rsp(6'd63, 17'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0));
      add_row(KEEP_COUNT, mk_req(OP_LEARN, 6'd42, 32'hFFFF_0000, 1'b1), 0, '0);
      add_row(KEEP_COUNT, mk_req(OP_LEARN, 6'd21, 32'h1234_5678, 1'b1), 0, '0);
      // first row again restarts the bounds of a learned column
      add_row(KEEP_COUNT, mk_req(OP_LEARN, 6'd1, 32'h0010_0000, 1'b1), 0, '0);
      add_row(KEEP_COUNT, mk_req(OP_NORMALIZE, 6'd1, 32'h0010_0000, 1'b0), 1,
              mk_rsp(6'd1, 17'd0, 32'h0010_0000, 32'h0010_0000, 1'b1, 1'b0));
      add_row(KEEP_COUNT, mk_req(OP_NORMALIZE, 6'd21, 32'h1234_5679, 1'b0), 1,
              mk_rsp(6'd21, 17'd0, 32'h1234_5678, 32'h1234_5678, 1'b1, 1'b0));
      // single column in use: everything else is ignored
      add_row(7'd1, mk_req(OP_LEARN, 6'd5, 32'h0000_0001, 1'b0), 0, '0);
      add_row(KEEP_COUNT, mk_req(OP_NORMALIZE, 6'd63, 32'h0000_0000, 1'b0), 0, '0);
      add_row(KEEP_COUNT, mk_req(OP_NORMALIZE, 6'd0, 32'h7FFF_FFFF, 1'b0), 1,
              mk_rsp(6'd0, 17'd65536, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0));
      add_row(7'd64, mk_req(OP_LEARN, 6'd42, 32'h0001_0000, 1'b0), 0, '0);
      add_row(KEEP_COUNT, mk_req(OP_NORMALIZE, 6'd42, 32'h0000_8000, 1'b1), 0, '0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      csr_write_count(7'd64);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].set_count != KEEP_COUNT) begin
            drain();
            csr_write_count(directed_rows[i].set_count);
         end
         issue(directed_rows[i].req, directed_rows[i].typed_ok, directed_rows[i].typed);
         pause_sender();
      end

      // random phases, alternating the extremes with random column counts
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         drain();
         if (ph == 0) csr_write_count(7'd1);
         else if (ph % 2 == 1) csr_write_count(7'd64);
         else csr_write_count(7'($urandom_range(2, 63)));
         repeat (PHASE_ITEMS) begin
            issue(gen_item(), 0, '0);
            pause_sender();
         end
      end

      start <= 1'b0;
      while (norm_expected.size() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);
      if (fail_count == 0 && norm_expected.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
